/* design/esf_pkg.sv */
`default_nettype none
package esf_pkg;

	// locator table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int KEY_W         = 48;

	// section framing
	localparam int SECTION_LIMIT = 4096;
	localparam int HEAD_BYTES    = 12;
	localparam int HDR_IDX_W     = $clog2(HEAD_BYTES);
	localparam int POS_W         = 13;
	localparam int LEN_W         = 12;
	localparam int LEN_MAX       = SECTION_LIMIT - 3;
	localparam int LEN_EXTRA     = 3;
	localparam int CFG_W         = 11;

	localparam logic [7:0] PF_TABLE_ID = 8'h4e;

	// route codes
	localparam logic [1:0] ROUTE_PRESENT   = 2'd0;
	localparam logic [1:0] ROUTE_FOLLOWING = 2'd1;
	localparam logic [1:0] ROUTE_RESTART   = 2'd2;
	localparam logic [1:0] ROUTE_APPEND    = 2'd3;

	// command codes
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_ENTRY = 1'b1;

	// status codes
	localparam logic STATUS_FWD  = 1'b0;
	localparam logic STATUS_STOP = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		key_t             data;
	} loc_wr_t;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_rsp_t;

	typedef struct packed {
		key_t       key;
		logic [1:0] route;
		logic [3:0] len_hi;
	} hdr_view_t;

endpackage
`default_nettype wire

/* design/esf_in_if.sv */
`default_nettype none
interface esf_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  data_byte;
	logic [9:0]  entry_index;
	logic [15:0] entry_network_id;
	logic [15:0] entry_stream_id;
	logic [15:0] entry_service_id;

	modport source (
		output valid, command, data_byte, entry_index,
		       entry_network_id, entry_stream_id, entry_service_id,
		input  ready
	);
	modport sink (
		input  valid, command, data_byte, entry_index,
		       entry_network_id, entry_stream_id, entry_service_id,
		output ready
	);
endinterface
`default_nettype wire

/* design/esf_out_if.sv */
`default_nettype none
interface esf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] route;
	logic       first_of_section;
	logic       last_of_section;
	logic       last_of_run;
	logic       status;

	modport source (
		output valid, out_byte, route, first_of_section, last_of_section,
		       last_of_run, status,
		input  ready
	);
	modport sink (
		input  valid, out_byte, route, first_of_section, last_of_section,
		       last_of_run, status,
		output ready
	);
endinterface
`default_nettype wire

/* design/esf_header.sv */
`default_nettype none
module esf_header (
	input  wire                           clk,
	input  wire                           we,
	input  wire  [esf_pkg::HDR_IDX_W-1:0] wpos,
	input  wire  [7:0]                    wbyte,
	input  wire  [esf_pkg::HDR_IDX_W-1:0] rd_idx,
	output logic [7:0]                    rd_byte,
	output esf_pkg::hdr_view_t            view
);

	logic [7:0] hdr_q [esf_pkg::HEAD_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			hdr_q[wpos] <= wbyte;
		end
	end

	// burst read of the held header
	assign rd_byte = (rd_idx < esf_pkg::HDR_IDX_W'(esf_pkg::HEAD_BYTES)) ? hdr_q[rd_idx] : 8'h00;

	// big endian ids: network 10-11, transport 8-9, service 3-4
	assign view.key    = {hdr_q[10], hdr_q[11], hdr_q[8], hdr_q[9], hdr_q[3], hdr_q[4]};
	assign view.len_hi = hdr_q[1][3:0];

	assign view.route = (hdr_q[0] == esf_pkg::PF_TABLE_ID)
		? ((hdr_q[6] == 8'h00) ? esf_pkg::ROUTE_PRESENT : esf_pkg::ROUTE_FOLLOWING)
		: ((hdr_q[6] == 8'h00) ? esf_pkg::ROUTE_RESTART : esf_pkg::ROUTE_APPEND);

endmodule
`default_nettype wire

/* design/esf_locator_search.sv */
`default_nettype none
module esf_locator_search (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire esf_pkg::loc_wr_t  wr,
	input  wire                    start,
	input  wire esf_pkg::key_t     key,
	input  wire esf_pkg::cnt_t     count,
	output esf_pkg::srch_rsp_t     rsp
);

	logic [esf_pkg::KEY_W-1:0] mem [esf_pkg::TABLE_ENTRIES];
	esf_pkg::key_t             rd_data_s1;
	esf_pkg::key_t             key_q;
	esf_pkg::cnt_t             count_q;
	esf_pkg::cnt_t             issue_q;
	logic                      busy_q;
	logic                      cmp_vld_s1;
	logic                      cmp_last_s1;
	logic                      done_q;
	logic                      hit_q;

	// single port use: writes and searches never overlap, the top holds
	// off input transfers while a search runs
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		rd_data_s1 <= mem[issue_q[esf_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q   <= key;
			count_q <= count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issue_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q     <= (count != '0);
				issue_q    <= '0;
				cmp_vld_s1 <= 1'b0;
				if (count == '0) begin
					done_q <= 1'b1;
					hit_q  <= 1'b0;
				end
			end else if (busy_q) begin
				// issue one read per cycle
				if (issue_q < count_q) begin
					cmp_vld_s1  <= 1'b1;
					cmp_last_s1 <= (issue_q + esf_pkg::CNT_W'(1) == count_q);
					issue_q     <= issue_q + esf_pkg::CNT_W'(1);
				end else begin
					cmp_vld_s1 <= 1'b0;
				end
				// compare the entry read last cycle, stop at first hit
				if (cmp_vld_s1 && rd_data_s1 == key_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= 1'b1;
				end else if (cmp_vld_s1 && cmp_last_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit  = hit_q;

endmodule
`default_nettype wire

/* design/eit_section_locator_filter_unit.sv */
`default_nettype none
// Event information section filter. Section bytes (command 0) and locator
// table writes (command 1) arrive on in_ch; forwarded bytes of sections whose
// service, transport and network ids appear among the first locator_count
// entries leave on out_ch with a route tag. One forwarded byte leaves per
// cycle while out_ch is ready. On byte 11 of a section of at least 12 bytes
// the input stalls while the locator memory is scanned, one entry per cycle
// through its single read port, ending early when an entry hits. A hit then
// sends the held header bytes, waiting whenever out_ch stalls, before the
// next input transfer. A length field above 4093 gives one status transfer
// and stops the filter until reset; locator writes still go in. The locator
// memory has no reset and needs no clearing pass. locator_count is written
// through cfg_we / cfg_wdata only while the block is idle; the user must keep
// to this, the block does not enforce it.
module eit_section_locator_filter_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [esf_pkg::CFG_W-1:0]      cfg_wdata,
	esf_in_if.sink                         in_ch,
	esf_out_if.source                      out_ch
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LAUNCH = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_BURST  = 2'd3;

	localparam int PW = esf_pkg::POS_W;

	logic [1:0]                    state_q;
	logic [esf_pkg::CFG_W-1:0]     loc_count_q;
	logic [PW-1:0]                 pos_q;
	logic [PW-1:0]                 len_q;
	logic [1:0]                    route_q;
	logic                          matched_q;
	logic                          stopped_q;
	logic [esf_pkg::HDR_IDX_W-1:0] burst_q;

	// output register
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_route_q;
	logic       out_first_q;
	logic       out_last_sec_q;
	logic       out_last_run_q;
	logic       out_status_q;

	esf_pkg::hdr_view_t  view;
	esf_pkg::loc_wr_t    loc_wr;
	esf_pkg::srch_rsp_t  rsp;
	esf_pkg::cnt_t       srch_count;
	logic [7:0]          burst_byte;

	logic                       out_free;
	logic                       acc;
	logic                       is_byte;
	logic [esf_pkg::LEN_W-1:0]  len_field;
	logic                       oversize;
	logic [PW-1:0]              len_new;
	logic [PW-1:0]              pos_next;
	logic                       sec_end;
	logic                       hdr_we;
	logic                       fwd;
	logic                       launch;
	logic                       burst_emit;
	logic                       burst_done;
	logic                       burst_sec_end;

	// the output register drains in the same cycle as it reloads
	assign out_free = !out_vld_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign acc = in_ch.valid && in_ch.ready;
	assign is_byte = acc && (in_ch.command == esf_pkg::CMD_BYTE) && !stopped_q;

	// length from header byte 1 (held) and byte 2 (arriving now)
	assign len_field = {view.len_hi, in_ch.data_byte};
	assign oversize  = (pos_q == PW'(2)) && (len_field > esf_pkg::LEN_W'(esf_pkg::LEN_MAX));
	assign len_new   = (pos_q == PW'(2)) ? (PW'(len_field) + PW'(esf_pkg::LEN_EXTRA)) : len_q;
	assign pos_next  = pos_q + PW'(1);
	assign sec_end   = (pos_next >= PW'(3)) && (pos_next >= len_new);

	assign hdr_we = is_byte && (pos_q < PW'(esf_pkg::HEAD_BYTES));
	assign fwd    = is_byte && (pos_q >= PW'(esf_pkg::HEAD_BYTES)) && matched_q;
	assign launch = is_byte && (pos_q == PW'(esf_pkg::HEAD_BYTES - 1))
	             && (len_q >= PW'(esf_pkg::HEAD_BYTES));

	assign burst_emit    = (state_q == ST_BURST) && out_free;
	assign burst_done    = burst_q == esf_pkg::HDR_IDX_W'(esf_pkg::HEAD_BYTES - 1);
	assign burst_sec_end = len_q == PW'(esf_pkg::HEAD_BYTES);

	// locator table writes, slots past the table are dropped
	assign loc_wr.en   = acc && (in_ch.command == esf_pkg::CMD_ENTRY)
	                  && (int'(in_ch.entry_index) < esf_pkg::TABLE_ENTRIES);
	assign loc_wr.idx  = in_ch.entry_index[esf_pkg::IDX_W-1:0];
	assign loc_wr.data = {in_ch.entry_network_id, in_ch.entry_stream_id,
	                      in_ch.entry_service_id};

	// clamp the entry count to the table size
	assign srch_count = (loc_count_q > esf_pkg::CFG_W'(esf_pkg::TABLE_ENTRIES))
	                  ? esf_pkg::CNT_W'(esf_pkg::TABLE_ENTRIES)
	                  : esf_pkg::CNT_W'(loc_count_q);

	esf_header u_header (
		.clk    (clk),
		.we     (hdr_we),
		.wpos   (pos_q[esf_pkg::HDR_IDX_W-1:0]),
		.wbyte  (in_ch.data_byte),
		.rd_idx (burst_q),
		.rd_byte(burst_byte),
		.view   (view)
	);

	esf_locator_search u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (loc_wr),
		.start (state_q == ST_LAUNCH),
		.key   (view.key),
		.count (srch_count),
		.rsp   (rsp)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_count_q <= '0;
		end else if (cfg_we) begin
			loc_count_q <= cfg_wdata;
		end
	end

	// section tracking and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			len_q     <= '0;
			route_q   <= esf_pkg::ROUTE_PRESENT;
			matched_q <= 1'b0;
			stopped_q <= 1'b0;
			burst_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_byte) begin
						if (oversize) begin
							// filter stops for good, length stays as it was
							stopped_q <= 1'b1;
							pos_q     <= '0;
							matched_q <= 1'b0;
						end else begin
							if (pos_q == PW'(2)) begin
								len_q <= len_new;
							end
							if (sec_end) begin
								pos_q     <= '0;
								matched_q <= 1'b0;
							end else begin
								pos_q <= pos_next;
							end
							if (launch) begin
								state_q <= ST_LAUNCH;
							end
						end
					end
				end
				ST_LAUNCH: begin
					// header is complete in the buffer, start the scan
					route_q <= view.route;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (rsp.done) begin
						// a twelve byte section ends with its header
						matched_q <= rsp.hit && !burst_sec_end;
						burst_q   <= '0;
						state_q   <= rsp.hit ? ST_BURST : ST_IDLE;
					end
				end
				ST_BURST: begin
					if (burst_emit) begin
						burst_q <= burst_q + esf_pkg::HDR_IDX_W'(1);
						if (burst_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((is_byte && oversize) || fwd || burst_emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (is_byte && oversize) begin
			out_byte_q     <= 8'h00;
			out_route_q    <= esf_pkg::ROUTE_PRESENT;
			out_first_q    <= 1'b0;
			out_last_sec_q <= 1'b0;
			out_last_run_q <= 1'b1;
			out_status_q   <= esf_pkg::STATUS_STOP;
		end else if (fwd) begin
			out_byte_q     <= in_ch.data_byte;
			out_route_q    <= route_q;
			out_first_q    <= 1'b0;
			out_last_sec_q <= (pos_next == len_q);
			out_last_run_q <= 1'b1;
			out_status_q   <= esf_pkg::STATUS_FWD;
		end else if (burst_emit) begin
			out_byte_q     <= burst_byte;
			out_route_q    <= route_q;
			out_first_q    <= (burst_q == '0);
			out_last_sec_q <= burst_done && burst_sec_end;
			out_last_run_q <= burst_done;
			out_status_q   <= esf_pkg::STATUS_FWD;
		end
	end

	assign out_ch.valid            = out_vld_q;
	assign out_ch.out_byte         = out_byte_q;
	assign out_ch.route            = out_route_q;
	assign out_ch.first_of_section = out_first_q;
	assign out_ch.last_of_section  = out_last_sec_q;
	assign out_ch.last_of_run      = out_last_run_q;
	assign out_ch.status           = out_status_q;

endmodule
`default_nettype wire
